### src/art_pkg.sv
// Shared types and constants for the ack/retransmit tracker.
// No dependencies; every other file imports this package.
package art_pkg;

  localparam int DEPTH       = 16;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int MAX_RESULTS = 17;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [3:0]  RETRY_RST   = 4'd3;

  typedef enum logic [1:0] {
    CMD_SEND  = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    EV_QUEUED    = 3'd0,
    EV_RESEND    = 3'd1,
    EV_GIVEN_UP  = 3'd2,
    EV_ACKED     = 3'd3,
    EV_UNMATCHED = 3'd4,
    EV_FULL      = 3'd5
  } event_t;

  typedef enum logic [0:0] {
    CFG_TIMEOUT = 1'b0,
    CFG_RETRY   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  seq;
    logic [7:0]  code;
    logic [31:0] tstamp;
    logic [3:0]  retries;
  } entry_t;

  // controller -> cell row
  typedef struct packed {
    logic load;       // write new entry at slot count
    logic latch_hit;  // capture ack match vector
    logic drop_hit;   // remove first matching entry
    logic drop_head;  // remove slot 0
    logic resend;     // restamp slot 0, bump retries
  } chain_ctl_t;

  // cell row -> controller
  typedef struct packed {
    entry_t head;
    logic   head_aged;
    logic   next_aged;
    logic   hit_any;
    entry_t hit;
  } chain_stat_t;

endpackage

### src/art_in_if.sv
// Input channel of the tracker: valid/ready plus one command item.
// Depends on art_pkg.
interface art_in_if import art_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  command_code;
  logic [7:0]  ack_seq;
  logic [31:0] now_time;

  modport source (output valid, cmd, command_code, ack_seq, now_time, input ready);
  modport sink   (input valid, cmd, command_code, ack_seq, now_time, output ready);
endinterface

### src/art_out_if.sv
// Result channel of the tracker: valid/ready plus one event item.
// Depends on art_pkg.
interface art_out_if import art_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] seq_out;
  logic [7:0] code_out;
  logic [3:0] retry_out;
  logic       last;

  modport source (output valid, event_res, seq_out, code_out, retry_out, last, input ready);
  modport sink   (input valid, event_res, seq_out, code_out, retry_out, last, output ready);
endinterface

### src/art_cell.sv
// One table slot: holds an entry, takes its right neighbor's entry on a shift,
// and flags age and ack match locally. Depends on art_pkg.
module art_cell import art_pkg::*; (
  input  logic        clk,
  input  logic        ld,
  input  logic        sh,
  input  logic        upd,
  input  entry_t      new_ent,
  input  entry_t      nbr_ent,
  input  logic [31:0] now,
  input  logic [15:0] timeout,
  input  logic [7:0]  ack_seq,
  output entry_t      ent,
  output logic        aged,
  output logic        hit
);

  entry_t      ent_r;
  entry_t      ent_nxt;
  logic [31:0] age;

  always_comb begin
    ent_nxt = ent_r;
    if (ld) begin
      ent_nxt = new_ent;
    end else if (sh) begin
      ent_nxt = nbr_ent;
    end else if (upd) begin
      ent_nxt.tstamp  = now;
      ent_nxt.retries = ent_r.retries + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign age  = now - ent_r.tstamp;
  assign aged = (age >= {16'd0, timeout});
  assign hit  = (ent_r.seq == ack_seq);
  assign ent  = ent_r;

endmodule

### src/art_chain.sv
// Row of DEPTH cells, oldest entry in slot 0, plus the first-match select for acks.
// Depends on art_pkg and art_cell.
module art_chain import art_pkg::*; (
  input  logic              clk,
  input  chain_ctl_t        ctl,
  input  logic [CNT_W-1:0]  count,
  input  entry_t            new_ent,
  input  logic [31:0]       now,
  input  logic [15:0]       timeout,
  input  logic [7:0]        ack_seq,
  output chain_stat_t       stat
);

  entry_t           ents [DEPTH+1];
  logic [DEPTH:0]   aged_w;
  logic [DEPTH-1:0] hit_w;
  logic [DEPTH-1:0] hit_r;
  logic [DEPTH-1:0] hit_nxt;
  logic [DEPTH-1:0] first;
  logic [DEPTH-1:0] pre;
  logic             seen;
  entry_t           sel;

  assign ents[DEPTH]   = '0;
  assign aged_w[DEPTH] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic ld_i;
    logic sh_i;
    logic upd_i;

    assign ld_i  = ctl.load && (count == CNT_W'(i));
    assign sh_i  = ctl.drop_head || (ctl.drop_hit && pre[i]);
    assign upd_i = ctl.resend && (i == 0);

    art_cell u_cell (
      .clk     (clk),
      .ld      (ld_i),
      .sh      (sh_i),
      .upd     (upd_i),
      .new_ent (new_ent),
      .nbr_ent (ents[i+1]),
      .now     (now),
      .timeout (timeout),
      .ack_seq (ack_seq),
      .ent     (ents[i]),
      .aged    (aged_w[i]),
      .hit     (hit_w[i])
    );

    // slots at or above count hold stale data
    assign hit_nxt[i] = hit_w[i] && (count > CNT_W'(i));
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_hit) begin
      hit_r <= hit_nxt;
    end
  end

  // first match and everything after it shifts left
  always_comb begin
    seen = 1'b0;
    sel  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      first[i] = hit_r[i] && !seen;
      seen     = seen || hit_r[i];
      pre[i]   = seen;
      if (first[i]) begin
        sel = ents[i];
      end
    end
  end

  assign stat.head      = ents[0];
  assign stat.head_aged = aged_w[0];
  assign stat.next_aged = aged_w[1];
  assign stat.hit_any   = |hit_r;
  assign stat.hit       = sel;

endmodule

### src/ack_retransmit_tracker_core.sv
// Top level of the ack/retransmit tracker: controller, config registers, result register.
// Depends on art_pkg, art_in_if, art_out_if and art_chain.
//
//   port     dir   kind            carries
//   in_ch    in    valid/ready     cmd, command_code, ack_seq, now_time
//   out_ch   out   valid/ready     event_res, seq_out, code_out, retry_out, last
//   cfg_*    in    write only      ack_timeout (index 0), retry_limit (index 1)
//
// Ack first captures the match vector, then selects and shifts.
// Tick walks from the head and reports up to one result per step: the walk examines
// cell 0 (cell 1 only for the look-ahead), one entry a cycle unless a result is waiting.
// A result waiting in the output register stalls every step that emits (send, ack and
// each walk step); acceptance in idle never waits on it.
// Reset (synchronous, rst_n low) empties the table and restores the register defaults.
module ack_retransmit_tracker_core import art_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  art_in_if.sink           in_ch,
  art_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_ACK  = 4'b0100,
    S_TICK = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [7:0]        code_r;
  logic [7:0]        aseq_r;
  logic [31:0]       now_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [7:0]        seq_r, seq_nxt;
  logic [NRES_W-1:0] nres_r, nres_nxt;
  logic [15:0]       timeout_r;
  logic [3:0]        limit_r;

  logic              ov_r;
  event_t            oev_r, oev_nxt;
  logic [7:0]        oseq_r, oseq_nxt;
  logic [7:0]        ocode_r, ocode_nxt;
  logic [3:0]        oret_r, oret_nxt;
  logic              olast_r, olast_nxt;

  logic              accept;
  logic              out_free;
  logic              emit;
  logic              full;
  chain_ctl_t        ctl;
  chain_stat_t       stat;
  entry_t            new_ent;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !ov_r || out_ch.ready;
  assign full     = (count_r >= CNT_W'(DEPTH));

  assign new_ent.seq     = seq_r;
  assign new_ent.code    = code_r;
  assign new_ent.tstamp  = now_r;
  assign new_ent.retries = 4'd0;

  art_chain u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .count   (count_r),
    .new_ent (new_ent),
    .now     (now_r),
    .timeout (timeout_r),
    .ack_seq (aseq_r),
    .stat    (stat)
  );

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    seq_nxt     = seq_r;
    nres_nxt    = nres_r;
    ctl         = '0;
    emit        = 1'b0;
    oev_nxt     = EV_QUEUED;
    oseq_nxt    = seq_r;
    ocode_nxt   = code_r;
    oret_nxt    = 4'd0;
    olast_nxt   = 1'b1;
    in_ch.ready = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (accept) begin
          state_nxt = S_EXEC;
          nres_nxt  = '0;
        end
      end
      S_EXEC: begin
        unique case (cmd_r)
          CMD_SEND: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (full) begin
                oev_nxt = EV_FULL;
              end else begin
                ctl.load  = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                seq_nxt   = seq_r + 8'd1;
              end
            end
          end
          CMD_ACK: begin
            ctl.latch_hit = 1'b1;
            state_nxt     = S_ACK;
          end
          CMD_TICK: begin
            state_nxt = S_TICK;
          end
          CMD_CLEAR: begin
            count_nxt = '0;
            seq_nxt   = 8'd0;
            state_nxt = S_IDLE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_ACK: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (stat.hit_any) begin
            oev_nxt      = EV_ACKED;
            oseq_nxt     = stat.hit.seq;
            ocode_nxt    = stat.hit.code;
            oret_nxt     = stat.hit.retries;
            ctl.drop_hit = 1'b1;
            count_nxt    = count_r - CNT_W'(1);
          end else begin
            oev_nxt   = EV_UNMATCHED;
            oseq_nxt  = aseq_r;
            ocode_nxt = 8'd0;
          end
        end
      end
      S_TICK: begin
        if (count_r == '0 || !stat.head_aged) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          emit      = 1'b1;
          oseq_nxt  = stat.head.seq;
          ocode_nxt = stat.head.code;
          if (stat.head.retries >= limit_r) begin
            oev_nxt       = EV_GIVEN_UP;
            oret_nxt      = stat.head.retries;
            ctl.drop_head = 1'b1;
            count_nxt     = count_r - CNT_W'(1);
            nres_nxt      = nres_r + NRES_W'(1);
            // look ahead: does the next entry report anything?
            olast_nxt = !((count_r > CNT_W'(1)) && stat.next_aged)
                        || (nres_nxt == NRES_W'(MAX_RESULTS));
            if (olast_nxt) begin
              state_nxt = S_IDLE;
            end
          end else begin
            oev_nxt    = EV_RESEND;
            oret_nxt   = stat.head.retries + 4'd1;
            ctl.resend = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      seq_r     <= 8'd0;
      nres_r    <= '0;
      ov_r      <= 1'b0;
      timeout_r <= TIMEOUT_RST;
      limit_r   <= RETRY_RST;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      seq_r   <= seq_nxt;
      nres_r  <= nres_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_TIMEOUT: timeout_r <= cfg_data;
          CFG_RETRY:   limit_r   <= cfg_data[3:0];
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd_t'(in_ch.cmd);
      code_r <= in_ch.command_code;
      aseq_r <= in_ch.ack_seq;
      now_r  <= in_ch.now_time;
    end
    if (emit) begin
      oev_r   <= oev_nxt;
      oseq_r  <= oseq_nxt;
      ocode_r <= ocode_nxt;
      oret_r  <= oret_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.event_res = oev_r;
  assign out_ch.seq_out   = oseq_r;
  assign out_ch.code_out  = ocode_r;
  assign out_ch.retry_out = oret_r;
  assign out_ch.last      = olast_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  a_ack_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACK && out_free && stat.hit_any) |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("matched ack did not remove an entry");

  a_send_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && cmd_r == CMD_SEND && out_free && !full)
    |=> seq_r == $past(seq_r) + 8'd1)
    else $error("queued send did not advance the sequence");

  a_resend_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oev_r == EV_RESEND) |-> olast_r)
    else $error("resend not flagged as final result");

  a_empty_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK && count_r == '0) |=> state_r == S_IDLE && !$rose(ov_r))
    else $error("tick on empty table produced a result");

endmodule
